>>> rtl/core/assert_macros.svh
// Assertion macros used by the top level of the circle unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in every cycle in which the antecedent holds.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The condition must never hold.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/core/cftp_pkg.sv
// Shared types and constants of the circle-from-three-points unit.
package cftp_pkg;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_COLLINEAR = 2'd1;
   localparam status_type STATUS_SATURATED = 2'd2;

   // Offset magnitudes are clamped to this value before the floor correction.
   localparam logic [40:0] OFFSET_LIMIT = 41'h100_0000_0000;

   localparam int RSP_DATA_W = 104;
   localparam int RESULT_W   = 32;
   localparam int ROOT_STAGES = 32;

   // Signs and the degenerate-case flag that travel beside the division.
   typedef struct packed {
      logic collinear;
      logic num_x_neg;
      logic num_y_neg;
      logic den_neg;
   } div_flags_type;

endpackage

>>> rtl/core/cftp_setup.sv
// Front end: edge vectors, squared lengths, determinant and center numerators.
module cftp_setup #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 in_valid,
   input  logic signed [COORD_WIDTH-1:0]        first_x,
   input  logic signed [COORD_WIDTH-1:0]        first_y,
   input  logic signed [COORD_WIDTH-1:0]        second_x,
   input  logic signed [COORD_WIDTH-1:0]        second_y,
   input  logic signed [COORD_WIDTH-1:0]        third_x,
   input  logic signed [COORD_WIDTH-1:0]        third_y,
   output logic                                 out_valid,
   output logic signed [COORD_WIDTH-1:0]        origin_x,
   output logic signed [COORD_WIDTH-1:0]        origin_y,
   output logic [3*(COORD_WIDTH+1)+1:0]         num_x_mag,
   output logic [3*(COORD_WIDTH+1)+1:0]         num_y_mag,
   output logic [2*(COORD_WIDTH+1)+1:0]         den_mag,
   output cftp_pkg::div_flags_type              flags
);
   import cftp_pkg::*;

   localparam int DW   = COORD_WIDTH + 1;
   localparam int PW   = 2 * DW;
   localparam int SQW  = 2 * DW + 1;
   localparam int DENW = 2 * DW + 2;
   localparam int NW   = 3 * DW + 2;

   // Stage 1: edge vectors from the first point.
   logic                   v1_ff;
   logic signed [COORD_WIDTH-1:0] ax1_ff, ay1_ff;
   logic signed [DW-1:0]   bx1_ff, by1_ff, cx1_ff, cy1_ff;
   // Stage 2: products.
   logic                   v2_ff;
   logic signed [COORD_WIDTH-1:0] ax2_ff, ay2_ff;
   logic signed [DW-1:0]   bx2_ff, by2_ff, cx2_ff, cy2_ff;
   logic signed [PW-1:0]   pbb_ff, pyy_ff, pcc_ff, pzz_ff, pbz_ff, pyc_ff;
   // Stage 3: squared lengths and doubled determinant.
   logic                   v3_ff;
   logic signed [COORD_WIDTH-1:0] ax3_ff, ay3_ff;
   logic signed [DW-1:0]   bx3_ff, by3_ff, cx3_ff, cy3_ff;
   logic signed [SQW-1:0]  b2_ff, c2_ff;
   logic signed [DENW-1:0] den3_ff;
   // Stage 4: numerator products.
   logic                   v4_ff;
   logic signed [COORD_WIDTH-1:0] ax4_ff, ay4_ff;
   logic signed [NW-2:0]   m1_ff, m2_ff, m3_ff, m4_ff;
   logic [DENW-1:0]        den4_ff;
   logic                   dneg4_ff, coll4_ff;
   // Stage 5: numerators as sign and magnitude.
   logic                   v5_ff;
   logic signed [COORD_WIDTH-1:0] ax5_ff, ay5_ff;
   logic [NW-1:0]          nxm5_ff, nym5_ff;
   logic [DENW-1:0]        den5_ff;
   div_flags_type          flags5_ff;

   logic signed [NW-1:0]   nx_in, ny_in;
   logic signed [DENW-1:0] cross_in;

   always_comb begin
      cross_in = DENW'(pbz_ff) - DENW'(pyc_ff);
      nx_in    = NW'(m1_ff) - NW'(m2_ff);
      ny_in    = NW'(m3_ff) - NW'(m4_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ax1_ff <= first_x;
         ay1_ff <= first_y;
         bx1_ff <= DW'(second_x) - DW'(first_x);
         by1_ff <= DW'(second_y) - DW'(first_y);
         cx1_ff <= DW'(third_x) - DW'(first_x);
         cy1_ff <= DW'(third_y) - DW'(first_y);

         ax2_ff <= ax1_ff;
         ay2_ff <= ay1_ff;
         bx2_ff <= bx1_ff;
         by2_ff <= by1_ff;
         cx2_ff <= cx1_ff;
         cy2_ff <= cy1_ff;
         pbb_ff <= PW'(bx1_ff) * PW'(bx1_ff);
         pyy_ff <= PW'(by1_ff) * PW'(by1_ff);
         pcc_ff <= PW'(cx1_ff) * PW'(cx1_ff);
         pzz_ff <= PW'(cy1_ff) * PW'(cy1_ff);
         pbz_ff <= PW'(bx1_ff) * PW'(cy1_ff);
         pyc_ff <= PW'(by1_ff) * PW'(cx1_ff);

         ax3_ff  <= ax2_ff;
         ay3_ff  <= ay2_ff;
         bx3_ff  <= bx2_ff;
         by3_ff  <= by2_ff;
         cx3_ff  <= cx2_ff;
         cy3_ff  <= cy2_ff;
         b2_ff   <= SQW'(pbb_ff) + SQW'(pyy_ff);
         c2_ff   <= SQW'(pcc_ff) + SQW'(pzz_ff);
         den3_ff <= cross_in <<< 1;

         ax4_ff   <= ax3_ff;
         ay4_ff   <= ay3_ff;
         m1_ff    <= (NW-1)'(cy3_ff) * (NW-1)'(b2_ff);
         m2_ff    <= (NW-1)'(by3_ff) * (NW-1)'(c2_ff);
         m3_ff    <= (NW-1)'(bx3_ff) * (NW-1)'(c2_ff);
         m4_ff    <= (NW-1)'(cx3_ff) * (NW-1)'(b2_ff);
         den4_ff  <= den3_ff[DENW-1] ? DENW'(-den3_ff) : DENW'(den3_ff);
         dneg4_ff <= den3_ff[DENW-1];
         coll4_ff <= (den3_ff == '0);

         ax5_ff               <= ax4_ff;
         ay5_ff               <= ay4_ff;
         nxm5_ff              <= nx_in[NW-1] ? NW'(-nx_in) : NW'(nx_in);
         nym5_ff              <= ny_in[NW-1] ? NW'(-ny_in) : NW'(ny_in);
         den5_ff              <= den4_ff;
         flags5_ff.collinear  <= coll4_ff;
         flags5_ff.num_x_neg  <= nx_in[NW-1];
         flags5_ff.num_y_neg  <= ny_in[NW-1];
         flags5_ff.den_neg    <= dneg4_ff;
      end
   end

   assign out_valid = v5_ff;
   assign origin_x  = ax5_ff;
   assign origin_y  = ay5_ff;
   assign num_x_mag = nxm5_ff;
   assign num_y_mag = nym5_ff;
   assign den_mag   = den5_ff;
   assign flags     = flags5_ff;

endmodule

>>> rtl/core/cftp_divider.sv
// Pipelined restoring divider: two numerators over one shared divisor, a bit per stage.
module cftp_divider #(
   parameter int NUM_W  = 53,
   parameter int DEN_W  = 36,
   parameter int SIDE_W = 36
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num_x,
   input  logic [NUM_W-1:0]  num_y,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [NUM_W-1:0]  quot_x,
   output logic [NUM_W-1:0]  quot_y,
   output logic              rem_x_nz,
   output logic              rem_y_nz,
   output logic [SIDE_W-1:0] side_out
);
   logic              v_ff    [NUM_W];
   logic [DEN_W-1:0]  rx_ff   [NUM_W];
   logic [DEN_W-1:0]  ry_ff   [NUM_W];
   logic [NUM_W-1:0]  nx_ff   [NUM_W];
   logic [NUM_W-1:0]  ny_ff   [NUM_W];
   logic [NUM_W-1:0]  qx_ff   [NUM_W];
   logic [NUM_W-1:0]  qy_ff   [NUM_W];
   logic [DEN_W-1:0]  d_ff    [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic              v_src;
      logic [DEN_W-1:0]  rx_src, ry_src, d_src;
      logic [NUM_W-1:0]  nx_src, ny_src, qx_src, qy_src;
      logic [SIDE_W-1:0] side_src;
      logic [DEN_W:0]    tx, ty, dext;
      logic              gex, gey;

      if (i == 0) begin : g_head
         assign v_src    = in_valid;
         assign rx_src   = '0;
         assign ry_src   = '0;
         assign nx_src   = num_x;
         assign ny_src   = num_y;
         assign qx_src   = '0;
         assign qy_src   = '0;
         assign d_src    = den;
         assign side_src = side_in;
      end else begin : g_body
         assign v_src    = v_ff[i-1];
         assign rx_src   = rx_ff[i-1];
         assign ry_src   = ry_ff[i-1];
         assign nx_src   = nx_ff[i-1];
         assign ny_src   = ny_ff[i-1];
         assign qx_src   = qx_ff[i-1];
         assign qy_src   = qy_ff[i-1];
         assign d_src    = d_ff[i-1];
         assign side_src = side_ff[i-1];
      end

      always_comb begin
         tx   = {rx_src, nx_src[NUM_W-1]};
         ty   = {ry_src, ny_src[NUM_W-1]};
         dext = {1'b0, d_src};
         gex  = (tx >= dext);
         gey  = (ty >= dext);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (advance) begin
            v_ff[i] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rx_ff[i]   <= gex ? DEN_W'(tx - dext) : tx[DEN_W-1:0];
            ry_ff[i]   <= gey ? DEN_W'(ty - dext) : ty[DEN_W-1:0];
            nx_ff[i]   <= nx_src << 1;
            ny_ff[i]   <= ny_src << 1;
            qx_ff[i]   <= {qx_src[NUM_W-2:0], gex};
            qy_ff[i]   <= {qy_src[NUM_W-2:0], gey};
            d_ff[i]    <= d_src;
            side_ff[i] <= side_src;
         end
      end
   end

   assign out_valid = v_ff[NUM_W-1];
   assign quot_x    = qx_ff[NUM_W-1];
   assign quot_y    = qy_ff[NUM_W-1];
   assign rem_x_nz  = |rx_ff[NUM_W-1];
   assign rem_y_nz  = |ry_ff[NUM_W-1];
   assign side_out  = side_ff[NUM_W-1];

endmodule

>>> rtl/core/cftp_sqrt.sv
// Pipelined integer square root of a 64-bit value, one result bit per stage.
module cftp_sqrt #(
   parameter int SIDE_W = 67
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [63:0]       radicand,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [31:0]       root,
   output logic [SIDE_W-1:0] side_out
);
   import cftp_pkg::*;

   logic              v_ff    [ROOT_STAGES];
   logic [33:0]       rem_ff  [ROOT_STAGES];
   logic [31:0]       root_ff [ROOT_STAGES];
   logic [63:0]       x_ff    [ROOT_STAGES];
   logic [SIDE_W-1:0] side_ff [ROOT_STAGES];

   for (genvar i = 0; i < ROOT_STAGES; i++) begin : g_stage
      logic              v_src;
      logic [33:0]       rem_src;
      logic [31:0]       root_src;
      logic [63:0]       x_src;
      logic [SIDE_W-1:0] side_src;
      logic [35:0]       trem, trial;
      logic              ge;

      if (i == 0) begin : g_head
         assign v_src    = in_valid;
         assign rem_src  = '0;
         assign root_src = '0;
         assign x_src    = radicand;
         assign side_src = side_in;
      end else begin : g_body
         assign v_src    = v_ff[i-1];
         assign rem_src  = rem_ff[i-1];
         assign root_src = root_ff[i-1];
         assign x_src    = x_ff[i-1];
         assign side_src = side_ff[i-1];
      end

      always_comb begin
         trem  = {rem_src, x_src[63:62]};
         trial = {2'b00, root_src, 2'b01};
         ge    = (trem >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (advance) begin
            v_ff[i] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i]  <= ge ? 34'(trem - trial) : trem[33:0];
            root_ff[i] <= {root_src[30:0], ge};
            x_ff[i]    <= x_src << 2;
            side_ff[i] <= side_src;
         end
      end
   end

   assign out_valid = v_ff[ROOT_STAGES-1];
   assign root      = root_ff[ROOT_STAGES-1];
   assign side_out  = side_ff[ROOT_STAGES-1];

endmodule

>>> rtl/core/circle_from_three_points_unit.sv
// Top level of the circle-from-three-points unit: circumcenter and radius of a point triple.
// Throughput: one request per cycle unless the output stalls; the center divider spends one
// stage per quotient bit and the square root one stage per radius bit, all stages fully pipelined.
// Every stage advances together whenever the result register is empty or being taken.
// Reset clears only the valid bits; the data registers are not reset.
`include "assert_macros.svh"

module circle_from_three_points_unit #(
   parameter int COORD_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   // Request: first_x, first_y, second_x, second_y, third_x, third_y from the lowest bit up.
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]     req_tdata,
   // Result: center_x[31:0], center_y[63:32], radius[95:64], status[97:96], zero above.
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [cftp_pkg::RSP_DATA_W-1:0]        rsp_tdata
);
   import cftp_pkg::*;

   localparam int DW    = COORD_WIDTH + 1;
   localparam int NW    = 3 * DW + 2;
   localparam int DENW  = 2 * DW + 2;
   localparam int MW    = (NW > 42) ? NW : 42;
   localparam int DSW   = 2 * COORD_WIDTH + $bits(div_flags_type);
   localparam int SSW   = 2 * RESULT_W + 3;

   localparam logic signed [41:0] Q_MAX = 42'sd1099511627776;
   localparam logic signed [41:0] Q_MIN = -42'sd1099511627777;
   localparam logic signed [42:0] C_MAX = 43'sd2147483647;
   localparam logic signed [42:0] C_MIN = -43'sd2147483648;

   // The whole pipeline moves in lock step; it holds only while a finished
   // result waits at the output and the downstream side is not taking it.
   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // Unpack the three points.
   logic signed [COORD_WIDTH-1:0] first_x, first_y, second_x, second_y, third_x, third_y;
   assign first_x  = req_tdata[0*COORD_WIDTH +: COORD_WIDTH];
   assign first_y  = req_tdata[1*COORD_WIDTH +: COORD_WIDTH];
   assign second_x = req_tdata[2*COORD_WIDTH +: COORD_WIDTH];
   assign second_y = req_tdata[3*COORD_WIDTH +: COORD_WIDTH];
   assign third_x  = req_tdata[4*COORD_WIDTH +: COORD_WIDTH];
   assign third_y  = req_tdata[5*COORD_WIDTH +: COORD_WIDTH];

   // Front end: numerators cy*|B|^2 - by*|C|^2 and bx*|C|^2 - cx*|B|^2 and the
   // doubled cross product, delivered as magnitudes with their signs.
   logic                          set_valid;
   logic signed [COORD_WIDTH-1:0] set_ax, set_ay;
   logic [NW-1:0]                 set_nx, set_ny;
   logic [DENW-1:0]               set_den;
   div_flags_type                 set_flags;

   cftp_setup #(.COORD_WIDTH(COORD_WIDTH)) u_setup (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .first_x   (first_x),
      .first_y   (first_y),
      .second_x  (second_x),
      .second_y  (second_y),
      .third_x   (third_x),
      .third_y   (third_y),
      .out_valid (set_valid),
      .origin_x  (set_ax),
      .origin_y  (set_ay),
      .num_x_mag (set_nx),
      .num_y_mag (set_ny),
      .den_mag   (set_den),
      .flags     (set_flags)
   );

   // Magnitude division of both numerators by the shared determinant.
   logic            div_valid;
   logic [NW-1:0]   div_qx, div_qy;
   logic            div_rx_nz, div_ry_nz;
   logic [DSW-1:0]  div_side;
   logic signed [COORD_WIDTH-1:0] div_ax, div_ay;
   div_flags_type   div_flags;

   cftp_divider #(.NUM_W(NW), .DEN_W(DENW), .SIDE_W(DSW)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (set_valid),
      .num_x     (set_nx),
      .num_y     (set_ny),
      .den       (set_den),
      .side_in   ({set_ax, set_ay, set_flags}),
      .out_valid (div_valid),
      .quot_x    (div_qx),
      .quot_y    (div_qy),
      .rem_x_nz  (div_rx_nz),
      .rem_y_nz  (div_ry_nz),
      .side_out  (div_side)
   );

   assign div_ax    = div_side[DSW-1 -: COORD_WIDTH];
   assign div_ay    = div_side[DSW-COORD_WIDTH-1 -: COORD_WIDTH];
   assign div_flags = div_side[$bits(div_flags_type)-1:0];

   // Turns a quotient magnitude into the floor of the signed quotient, with
   // the magnitude clamped to the offset limit before the floor correction.
   function automatic logic signed [41:0] floor_quot(input logic [NW-1:0] quot,
                                                      input logic neg,
                                                      input logic rem_nz);
      logic [MW-1:0] wide;
      logic [40:0]   mag;
      logic [41:0]   adj;
      wide = MW'(quot);
      mag  = (wide > MW'(OFFSET_LIMIT)) ? OFFSET_LIMIT : wide[40:0];
      adj  = {1'b0, mag} + 42'(neg & rem_nz);
      return neg ? -$signed(adj) : $signed(adj);
   endfunction

   // Stage F1: signed, rounded offsets from the first point.
   logic                          f1_valid_ff;
   logic signed [41:0]            f1_qx_ff, f1_qy_ff;
   logic signed [COORD_WIDTH-1:0] f1_ax_ff, f1_ay_ff;
   logic                          f1_coll_ff;
   // Stage F2: clamped center and offset magnitudes.
   logic                          f2_valid_ff;
   logic [RESULT_W-1:0]           f2_cx_ff, f2_cy_ff;
   logic [31:0]                   f2_mx_ff, f2_my_ff;
   logic                          f2_sat_ff, f2_rsat_ff, f2_coll_ff;
   // Stage F3: squared offsets.
   logic                          f3_valid_ff;
   logic [RESULT_W-1:0]           f3_cx_ff, f3_cy_ff;
   logic [63:0]                   f3_sx_ff, f3_sy_ff;
   logic                          f3_sat_ff, f3_rsat_ff, f3_coll_ff;
   // Stage F4: squared radius.
   logic                          f4_valid_ff;
   logic [63:0]                   f4_r2_ff;
   logic [SSW-1:0]                f4_side_ff;

   logic signed [42:0] ux_in, uy_in;
   logic signed [41:0] amx_in, amy_in;
   logic [RESULT_W-1:0] cx_in, cy_in;
   logic               satx_in, saty_in;
   logic [64:0]        r2_in;

   always_comb begin
      ux_in   = 43'(f1_ax_ff) + 43'(f1_qx_ff);
      uy_in   = 43'(f1_ay_ff) + 43'(f1_qy_ff);
      satx_in = (ux_in > C_MAX) || (ux_in < C_MIN);
      saty_in = (uy_in > C_MAX) || (uy_in < C_MIN);
      if (ux_in > C_MAX) begin
         cx_in = 32'h7FFF_FFFF;
      end else if (ux_in < C_MIN) begin
         cx_in = 32'h8000_0000;
      end else begin
         cx_in = ux_in[RESULT_W-1:0];
      end
      if (uy_in > C_MAX) begin
         cy_in = 32'h7FFF_FFFF;
      end else if (uy_in < C_MIN) begin
         cy_in = 32'h8000_0000;
      end else begin
         cy_in = uy_in[RESULT_W-1:0];
      end
      amx_in = f1_qx_ff[41] ? -f1_qx_ff : f1_qx_ff;
      amy_in = f1_qy_ff[41] ? -f1_qy_ff : f1_qy_ff;
      r2_in  = {1'b0, f3_sx_ff} + {1'b0, f3_sy_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
         f4_valid_ff <= 1'b0;
      end else if (advance) begin
         f1_valid_ff <= div_valid;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
         f4_valid_ff <= f3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_qx_ff   <= floor_quot(div_qx, div_flags.num_x_neg ^ div_flags.den_neg, div_rx_nz);
         f1_qy_ff   <= floor_quot(div_qy, div_flags.num_y_neg ^ div_flags.den_neg, div_ry_nz);
         f1_ax_ff   <= div_ax;
         f1_ay_ff   <= div_ay;
         f1_coll_ff <= div_flags.collinear;

         f2_cx_ff   <= cx_in;
         f2_cy_ff   <= cy_in;
         f2_mx_ff   <= amx_in[31:0];
         f2_my_ff   <= amy_in[31:0];
         f2_sat_ff  <= satx_in || saty_in;
         f2_rsat_ff <= (|amx_in[41:32]) || (|amy_in[41:32]);
         f2_coll_ff <= f1_coll_ff;

         f3_cx_ff   <= f2_cx_ff;
         f3_cy_ff   <= f2_cy_ff;
         f3_sx_ff   <= 64'(f2_mx_ff) * 64'(f2_mx_ff);
         f3_sy_ff   <= 64'(f2_my_ff) * 64'(f2_my_ff);
         f3_sat_ff  <= f2_sat_ff;
         f3_rsat_ff <= f2_rsat_ff;
         f3_coll_ff <= f2_coll_ff;

         f4_r2_ff   <= r2_in[63:0];
         f4_side_ff <= {f3_cx_ff, f3_cy_ff, f3_sat_ff, f3_rsat_ff || r2_in[64], f3_coll_ff};
      end
   end

   // Radius as the floor square root of the squared rounded offset.
   logic                 sq_valid;
   logic [31:0]          sq_root;
   logic [SSW-1:0]       sq_side;
   logic [RESULT_W-1:0]  sq_cx, sq_cy;
   logic                 sq_sat, sq_rsat, sq_coll;

   cftp_sqrt #(.SIDE_W(SSW)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (f4_valid_ff),
      .radicand  (f4_r2_ff),
      .side_in   (f4_side_ff),
      .out_valid (sq_valid),
      .root      (sq_root),
      .side_out  (sq_side)
   );

   assign sq_cx   = sq_side[SSW-1 -: RESULT_W];
   assign sq_cy   = sq_side[SSW-RESULT_W-1 -: RESULT_W];
   assign sq_sat  = sq_side[2];
   assign sq_rsat = sq_side[1];
   assign sq_coll = sq_side[0];

   // Result register. Collinear triples report zeros; any clamp reports saturation.
   logic                rsp_valid_ff;
   logic [RESULT_W-1:0] rsp_cx_ff, rsp_cy_ff, rsp_rad_ff;
   status_type          rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (sq_coll) begin
            rsp_cx_ff     <= '0;
            rsp_cy_ff     <= '0;
            rsp_rad_ff    <= '0;
            rsp_status_ff <= STATUS_COLLINEAR;
         end else begin
            rsp_cx_ff     <= sq_cx;
            rsp_cy_ff     <= sq_cy;
            rsp_rad_ff    <= sq_rsat ? '1 : sq_root;
            rsp_status_ff <= (sq_sat || sq_rsat) ? STATUS_SATURATED : STATUS_OK;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_status_ff, rsp_rad_ff, rsp_cy_ff, rsp_cx_ff};

   `ASSERT_NEVER(a_status_code, clock, reset, rsp_tvalid && (rsp_status_ff != STATUS_OK) && (rsp_status_ff != STATUS_COLLINEAR) && (rsp_status_ff != STATUS_SATURATED), "undefined status code on a result")
   `ASSERT_IMPLIES(a_collinear_zero, clock, reset, rsp_tvalid && (rsp_status_ff == STATUS_COLLINEAR), (rsp_cx_ff == '0) && (rsp_cy_ff == '0) && (rsp_rad_ff == '0), "collinear result carries nonzero fields")
   `ASSERT_IMPLIES(a_offset_bound, clock, reset, f1_valid_ff && !f1_coll_ff, (f1_qx_ff <= Q_MAX) && (f1_qx_ff >= Q_MIN) && (f1_qy_ff <= Q_MAX) && (f1_qy_ff >= Q_MIN), "rounded offset outside the clamp range")

endmodule
